// ===== design/rsl_pkg.sv =====
package rsl_pkg;

    // Command codes carried in the input item
    typedef enum logic [1:0] {
        CMD_SAMPLE  = 2'd0,
        CMD_RESTART = 2'd1,
        CMD_READ    = 2'd2,
        CMD_STOP    = 2'd3
    } cmd_e;

    // Result status codes
    typedef enum logic [2:0] {
        STS_NONFINITE = 3'd0,
        STS_APPENDED  = 3'd1,
        STS_REPLACED  = 3'd2,
        STS_DISCARDED = 3'd3,
        STS_RESTARTED = 3'd4,
        STS_READ_OK   = 3'd5,
        STS_INACTIVE  = 3'd6,
        STS_READ_OOR  = 3'd7
    } status_e;

    // Top-level sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LCG,
        ST_DIV,
        ST_DONE
    } state_e;

    // Generator step phases
    typedef enum logic [1:0] {
        LP_IDLE,
        LP_HI,
        LP_SUM
    } lcg_phase_e;

    localparam int          COORD_W    = 32;
    localparam int          CAP_CFG_W  = 11;
    localparam int          LCG_W      = 64;
    localparam int          LCG_MUL_W  = 21;
    localparam int          LCG_SHIFT  = 16;
    localparam int          DVD_W      = LCG_W - LCG_SHIFT;
    localparam int          DVD_CNT_W  = $clog2(DVD_W);

    localparam logic [LCG_MUL_W-1:0] LCG_MUL  = 21'd1664525;
    localparam logic [31:0]          LCG_ADD  = 32'd1013904223;
    localparam logic [LCG_W-1:0]     LCG_SEED = 64'h9E3779B97F4A7C15;
    localparam logic [CAP_CFG_W-1:0] CAP_RESET = 11'd1024;

    typedef struct packed {
        logic [1:0]         command;
        logic [COORD_W-1:0] sample_x;
        logic [COORD_W-1:0] sample_y;
        logic [COORD_W-1:0] sample_z;
        logic [9:0]         read_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [31:0]        seen_count;
        logic [10:0]        stored_count;
        logic [9:0]         slot_used;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [COORD_W-1:0] out_z;
    } out_item_t;

    // Exponent field all ones: infinity or NaN
    function automatic logic is_nonfinite(input logic [COORD_W-1:0] bits);
        return &bits[30:23];
    endfunction

endpackage

// ===== design/rsl_lcg_step.sv =====
module rsl_lcg_step (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [rsl_pkg::LCG_W-1:0]     state_in,
    output logic                          done,
    output logic [rsl_pkg::LCG_W-1:0]     state_out
);

    rsl_pkg::lcg_phase_e phase_reg, phase_next;
    logic                done_reg, done_next;
    logic [53:0]         acc_reg;
    logic [31:0]         hi_prod_reg;
    logic [rsl_pkg::LCG_W-1:0] res_reg;

    logic [31:0]                       mul_a;
    logic [31+rsl_pkg::LCG_MUL_W:0]    mul_p;

    // One 32x21 multiplier, shared by the low and high halves
    assign mul_a = start ? state_in[31:0] : state_in[63:32];
    assign mul_p = mul_a * rsl_pkg::LCG_MUL;

    always_comb begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        case (phase_reg)
            rsl_pkg::LP_IDLE: begin
                if (start) begin
                    phase_next = rsl_pkg::LP_HI;
                end
            end
            rsl_pkg::LP_HI: begin
                phase_next = rsl_pkg::LP_SUM;
            end
            rsl_pkg::LP_SUM: begin
                phase_next = rsl_pkg::LP_IDLE;
                done_next  = 1'b1;
            end
            default: begin
                phase_next = rsl_pkg::LP_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= rsl_pkg::LP_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (phase_reg == rsl_pkg::LP_IDLE && start) begin
            acc_reg <= 54'(mul_p) + 54'(rsl_pkg::LCG_ADD);
        end
        if (phase_reg == rsl_pkg::LP_HI) begin
            hi_prod_reg <= mul_p[31:0];
        end
        if (phase_reg == rsl_pkg::LP_SUM) begin
            res_reg <= 64'(acc_reg) + {hi_prod_reg, 32'h0};
        end
    end

    assign done      = done_reg;
    assign state_out = res_reg;

endmodule

// ===== design/rsl_rem_unit.sv =====
module rsl_rem_unit #(
    parameter int CW = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [rsl_pkg::DVD_W-1:0]     dividend,
    input  logic [CW-1:0]                 divisor,
    output logic                          done,
    output logic [CW-1:0]                 remainder
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [rsl_pkg::DVD_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [rsl_pkg::DVD_W-1:0]         dvd_reg, dvd_next;
    logic [CW-1:0]                     rem_reg, rem_next;
    logic [CW-1:0]                     div_reg, div_next;

    logic [CW:0] trial;
    logic [CW:0] diff;

    // Restoring remainder, one dividend bit per cycle
    assign trial = {rem_reg, dvd_reg[rsl_pkg::DVD_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[rsl_pkg::DVD_W-2:0], 1'b0};
            rem_next = (trial >= {1'b0, div_reg}) ? diff[CW-1:0] : trial[CW-1:0];
            cnt_next = cnt_reg + rsl_pkg::DVD_CNT_W'(1);
            if (cnt_reg == rsl_pkg::DVD_CNT_W'(rsl_pkg::DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== design/reservoir_sampler_lcg.sv =====
// Reservoir sampler (Algorithm R) for 3D points, one command per input
// transfer and one result per command. Restart and stop clear the counts and
// reseed the 64-bit LCG; restart arms the sampler, stop disarms it. A finite
// sample is appended while the store holds fewer than capacity entries;
// after that the LCG advances and (state >> 16) mod seen picks a slot that
// is replaced if it is below the stored count. Commands run one at a time:
// restart, stop, read, append and rejected samples go from execute straight to
// done; a sample that draws a slot runs the LCG step (low product, high
// product, sum) on a shared 32x21 multiplier and the 48-step remainder unit
// that retires one dividend bit per cycle. A finished result waits in the
// output register, so the next command can be taken while it is still
// unclaimed. Capacity is written through cfg_wr_en / cfg_wr_data while idle,
// a rule on the user, unchecked here; values above DEPTH act as DEPTH.
// Reservoir entries are not reset and are only returned below the stored count.
module reservoir_sampler_lcg #(
    parameter int DEPTH       = 1024,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  rsl_pkg::in_item_t                     s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output rsl_pkg::out_item_t                    m_data,
    input  logic                                  cfg_wr_en,
    input  logic [rsl_pkg::CAP_CFG_W-1:0]         cfg_wr_data
);

    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CAP_W  = (FILL_W > rsl_pkg::CAP_CFG_W) ? FILL_W : rsl_pkg::CAP_CFG_W;
    localparam int IX_W   = (FILL_W > 10) ? FILL_W : 10;
    localparam int PK_W   = (COUNT_WIDTH > FILL_W) ? COUNT_WIDTH : FILL_W;
    localparam int ENT_W  = 3 * rsl_pkg::COORD_W;

    // Sequencer and run state
    rsl_pkg::state_e                     state_reg, state_next;
    logic                                m_valid_reg, m_valid_next;
    logic                                active_reg, active_next;
    logic [COUNT_WIDTH-1:0]              seen_reg, seen_next;
    logic [FILL_W-1:0]                   fill_reg, fill_next;
    logic [rsl_pkg::LCG_W-1:0]           lcg_reg, lcg_next;
    logic [rsl_pkg::CAP_CFG_W-1:0]       cap_reg;

    // Payload holding registers
    rsl_pkg::in_item_t                   item_reg, item_next;
    rsl_pkg::status_e                    res_status_reg, res_status_next;
    logic [9:0]                          res_slot_reg, res_slot_next;
    rsl_pkg::out_item_t                  m_data_reg, m_data_next;
    logic [ENT_W-1:0]                    rd_data_reg;

    // Reservoir store
    logic [ENT_W-1:0]                    mem [DEPTH];
    logic                                mem_we, mem_re;
    logic [IDX_W-1:0]                    mem_waddr, mem_raddr;
    logic [ENT_W-1:0]                    mem_wdata;

    // Shared units
    logic                                lcg_start, lcg_done;
    logic [rsl_pkg::LCG_W-1:0]           lcg_res;
    logic                                rem_start, rem_done;
    logic [COUNT_WIDTH-1:0]              rem_val;

    // Decode of the held command
    rsl_pkg::cmd_e                       cmd;
    logic                                sample_bad;
    logic                                below_cap;
    logic                                idx_ok;
    logic                                pick_ok;
    logic                                need_lcg;
    logic                                out_free;
    logic                                load_out;

    assign cmd        = rsl_pkg::cmd_e'(item_reg.command);
    assign sample_bad = rsl_pkg::is_nonfinite(item_reg.sample_x)
                      | rsl_pkg::is_nonfinite(item_reg.sample_y)
                      | rsl_pkg::is_nonfinite(item_reg.sample_z);
    // Effective capacity is min(capacity, DEPTH)
    assign below_cap  = (CAP_W'(fill_reg) < CAP_W'(cap_reg))
                      && (CAP_W'(fill_reg) < CAP_W'(DEPTH));
    assign idx_ok     = (IX_W'(item_reg.read_index) < IX_W'(fill_reg))
                      && (IX_W'(item_reg.read_index) < IX_W'(DEPTH));
    assign pick_ok    = PK_W'(rem_val) < PK_W'(fill_reg);
    assign need_lcg   = (cmd == rsl_pkg::CMD_SAMPLE) && active_reg && !sample_bad
                      && !below_cap;
    assign out_free   = !m_valid_reg || m_ready;
    assign load_out   = (state_reg == rsl_pkg::ST_DONE) && out_free;

    rsl_lcg_step u_lcg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (lcg_start),
        .state_in  (lcg_reg),
        .done      (lcg_done),
        .state_out (lcg_res)
    );

    rsl_rem_unit #(
        .CW (COUNT_WIDTH)
    ) u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rem_start),
        .dividend  (lcg_res[rsl_pkg::LCG_W-1:rsl_pkg::LCG_SHIFT]),
        .divisor   (seen_reg),
        .done      (rem_done),
        .remainder (rem_val)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rsl_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = rsl_pkg::ST_EXEC;
                end
            end
            rsl_pkg::ST_EXEC: begin
                state_next = need_lcg ? rsl_pkg::ST_LCG : rsl_pkg::ST_DONE;
            end
            rsl_pkg::ST_LCG: begin
                if (lcg_done) begin
                    state_next = rsl_pkg::ST_DIV;
                end
            end
            rsl_pkg::ST_DIV: begin
                if (rem_done) begin
                    state_next = rsl_pkg::ST_DONE;
                end
            end
            rsl_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = rsl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rsl_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and handshake outputs
    always_comb begin
        s_ready         = 1'b0;
        lcg_start       = 1'b0;
        rem_start       = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = IDX_W'(fill_reg);
        mem_raddr       = IDX_W'(item_reg.read_index);
        mem_wdata       = {item_reg.sample_x, item_reg.sample_y, item_reg.sample_z};
        active_next     = active_reg;
        seen_next       = seen_reg;
        fill_next       = fill_reg;
        lcg_next        = lcg_reg;
        item_next       = item_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg && !m_ready;

        case (state_reg)
            rsl_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_next = s_data;
                end
            end
            rsl_pkg::ST_EXEC: begin
                res_slot_next = '0;
                case (cmd)
                    rsl_pkg::CMD_RESTART, rsl_pkg::CMD_STOP: begin
                        seen_next       = '0;
                        fill_next       = '0;
                        lcg_next        = rsl_pkg::LCG_SEED;
                        active_next     = (cmd == rsl_pkg::CMD_RESTART);
                        res_status_next = (cmd == rsl_pkg::CMD_RESTART)
                                        ? rsl_pkg::STS_RESTARTED : rsl_pkg::STS_INACTIVE;
                    end
                    rsl_pkg::CMD_READ: begin
                        mem_re          = 1'b1;
                        res_status_next = idx_ok ? rsl_pkg::STS_READ_OK
                                                 : rsl_pkg::STS_READ_OOR;
                    end
                    default: begin
                        if (!active_reg) begin
                            res_status_next = rsl_pkg::STS_INACTIVE;
                        end else if (sample_bad) begin
                            res_status_next = rsl_pkg::STS_NONFINITE;
                        end else begin
                            // saturate the seen count
                            if (seen_reg != '1) begin
                                seen_next = seen_reg + COUNT_WIDTH'(1);
                            end
                            if (below_cap) begin
                                mem_we          = 1'b1;
                                fill_next       = fill_reg + FILL_W'(1);
                                res_slot_next   = 10'(mem_waddr);
                                res_status_next = rsl_pkg::STS_APPENDED;
                            end else begin
                                lcg_start = 1'b1;
                            end
                        end
                    end
                endcase
            end
            rsl_pkg::ST_LCG: begin
                // commit the new generator state and draw the slot
                if (lcg_done) begin
                    lcg_next  = lcg_res;
                    rem_start = 1'b1;
                end
            end
            rsl_pkg::ST_DIV: begin
                mem_waddr = IDX_W'(rem_val);
                if (rem_done) begin
                    if (pick_ok) begin
                        mem_we          = 1'b1;
                        res_slot_next   = 10'(mem_waddr);
                        res_status_next = rsl_pkg::STS_REPLACED;
                    end else begin
                        res_status_next = rsl_pkg::STS_DISCARDED;
                    end
                end
            end
            rsl_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next.status        = res_status_reg;
                    m_data_next.seen_count    = 32'(seen_reg);
                    m_data_next.stored_count  = 11'(fill_reg);
                    m_data_next.slot_used     = res_slot_reg;
                    if (res_status_reg == rsl_pkg::STS_READ_OK) begin
                        m_data_next.out_x = rd_data_reg[ENT_W-1 -: rsl_pkg::COORD_W];
                        m_data_next.out_y = rd_data_reg[2*rsl_pkg::COORD_W-1 -:
                                                        rsl_pkg::COORD_W];
                        m_data_next.out_z = rd_data_reg[rsl_pkg::COORD_W-1:0];
                    end else begin
                        m_data_next.out_x = '0;
                        m_data_next.out_y = '0;
                        m_data_next.out_z = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rsl_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            active_reg  <= 1'b0;
            seen_reg    <= '0;
            fill_reg    <= '0;
            lcg_reg     <= rsl_pkg::LCG_SEED;
            cap_reg     <= rsl_pkg::CAP_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            active_reg  <= active_next;
            seen_reg    <= seen_next;
            fill_reg    <= fill_next;
            lcg_reg     <= lcg_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        item_reg       <= item_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        if (load_out) begin
            m_data_reg <= m_data_next;
        end
    end

    // Reservoir: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
